// ===== rtl/tbu_pkg.sv =====
package tbu_pkg;

    localparam int WORD_BITS    = 10;
    localparam int PIXEL_SHIFT  = 6;
    localparam int IMAGE_ROWS   = 2708;
    localparam int ACC_BITS     = 17;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_DATA_W   = 14;
    localparam int CFG_INDEX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_SKIP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WORDS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_START  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_START = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_THIRD_START  = 3'd5;

    // Reset values
    localparam logic [2:0]  RST_LEAD_SKIP    = 3'd4;
    localparam logic [13:0] RST_FRAME_WORDS  = 14'd15538;
    localparam logic [12:0] RST_LINE_WIDTH   = 13'd5000;
    localparam logic [13:0] RST_FIRST_START  = 14'd90;
    localparam logic [13:0] RST_SECOND_START = 14'd5316;
    localparam logic [13:0] RST_THIRD_START  = 14'd10538;

    typedef struct packed {
        logic [2:0]  lead_skip_bits;
        logic [13:0] frame_word_count;
        logic [12:0] line_width;
        logic [13:0] first_window_start;
        logic [13:0] second_window_start;
        logic [13:0] third_window_start;
    } t_cfg;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [13:0]          index;
        logic [10:0]          line_pair;
    } t_word;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic        channel_id;
        logic [11:0] image_row;
        logic [12:0] image_column;
        logic        pair_of_rows;
    } t_pix_entry;

endpackage

// ===== rtl/tbu_unpack.sv =====
module tbu_unpack
    import tbu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_frame_start,
    input  logic [10:0] i_line_pair,
    output logic        o_word_valid,
    output t_word       o_word
);

    logic [ACC_BITS-1:0] r_acc;
    logic [4:0]          r_held;
    logic [13:0]         r_index;
    logic [2:0]          r_skip;
    logic                r_word_valid;
    t_word               r_word;

    logic [ACC_BITS-1:0] acc_e;
    logic [4:0]          held_e;
    logic [13:0]         idx_e;
    logic [2:0]          skip_e;
    logic                active;
    logic [ACC_BITS+7:0] shifted;
    logic [ACC_BITS-1:0] acc_cat;
    logic [4:0]          held_sum;
    logic                done;
    logic [4:0]          held_rem;
    logic [WORD_BITS-1:0] word;
    logic [ACC_BITS-1:0] n_acc;

    always_comb begin
        acc_e    = i_frame_start ? '0 : r_acc;
        held_e   = i_frame_start ? '0 : r_held;
        idx_e    = i_frame_start ? '0 : r_index;
        skip_e   = i_frame_start ? i_cfg.lead_skip_bits : r_skip;
        active   = idx_e < i_cfg.frame_word_count;
        // append the kept low bits of the byte below the held bits
        shifted  = {acc_e, 8'h00} >> skip_e;
        acc_cat  = shifted[ACC_BITS-1:0] | {9'd0, i_byte & (8'hFF >> skip_e)};
        held_sum = held_e + (5'd8 - {2'b00, skip_e});
        done     = held_sum >= 5'(WORD_BITS);
        held_rem = done ? held_sum - 5'(WORD_BITS) : held_sum;
        word     = WORD_BITS'(acc_cat >> held_rem);
        n_acc    = done ? (acc_cat & ((ACC_BITS'(1) << held_rem) - ACC_BITS'(1))) : acc_cat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_held       <= '0;
            r_index      <= '0;
            r_skip       <= '0;
            r_word_valid <= 1'b0;
        end else begin
            r_word_valid <= i_accept & active & done;
            if (i_accept) begin
                if (active) begin
                    r_acc   <= n_acc;
                    r_held  <= held_rem;
                    r_skip  <= '0;
                    r_index <= done ? idx_e + 14'd1 : idx_e;
                end else begin
                    // past frame length: hold, but keep the frame-start clear
                    r_acc   <= acc_e;
                    r_held  <= held_e;
                    r_index <= idx_e;
                    r_skip  <= skip_e;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word.word      <= word;
            r_word.index     <= idx_e;
            r_word.line_pair <= i_line_pair;
        end
    end

    assign o_word_valid = r_word_valid;
    assign o_word       = r_word;

endmodule

// ===== rtl/tbu_window.sv =====
module tbu_window
    import tbu_pkg::*;
(
    input  t_cfg       i_cfg,
    input  logic       i_word_valid,
    input  t_word      i_word,
    output logic       o_push,
    output t_pix_entry o_entry
);

    logic [14:0] end1, end2, end3;
    logic        in1, in2, in3;
    logic [11:0] row0, row1;
    logic        ok0, ok1;
    logic        hit;

    always_comb begin
        end1 = {1'b0, i_cfg.first_window_start}  + {2'b00, i_cfg.line_width};
        end2 = {1'b0, i_cfg.second_window_start} + {2'b00, i_cfg.line_width};
        end3 = {1'b0, i_cfg.third_window_start}  + {2'b00, i_cfg.line_width};
        in1  = (i_word.index >= i_cfg.first_window_start)  && ({1'b0, i_word.index} < end1);
        in2  = (i_word.index >= i_cfg.second_window_start) && ({1'b0, i_word.index} < end2);
        in3  = (i_word.index >= i_cfg.third_window_start)  && ({1'b0, i_word.index} < end3);
        row0 = {i_word.line_pair, 1'b0};
        row1 = {i_word.line_pair, 1'b1};
        ok0  = {1'b0, row0} < 13'(IMAGE_ROWS);
        ok1  = {1'b0, row1} < 13'(IMAGE_ROWS);

        o_entry.pixel_value = {i_word.word, {PIXEL_SHIFT{1'b0}}};
        o_entry.channel_id   = 1'b0;
        o_entry.image_row    = row0;
        o_entry.image_column = 13'(i_word.index - i_cfg.first_window_start);
        o_entry.pair_of_rows = 1'b0;
        hit = 1'b0;
        if (in1) begin
            hit = ok0;
        end else if (in2) begin
            hit                  = ok1;
            o_entry.image_row    = row1;
            o_entry.image_column = 13'(i_word.index - i_cfg.second_window_start);
        end else if (in3) begin
            // odd row can only survive if the even row does
            hit                  = ok0;
            o_entry.channel_id   = 1'b1;
            o_entry.image_column = 13'(i_word.index - i_cfg.third_window_start);
            o_entry.pair_of_rows = ok1;
        end
        o_push = i_word_valid & hit;
    end

endmodule

// ===== rtl/tbu_out_queue.sv =====
module tbu_out_queue
    import tbu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_pix_entry        i_entry,
    output logic [QCNT_W-1:0] o_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_pixel_value,
    output logic              o_channel_id,
    output logic [11:0]       o_image_row,
    output logic [12:0]       o_image_column,
    output logic              o_last
);

    t_pix_entry        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              r_second;

    t_pix_entry        head;
    logic              fire;
    logic              pop;

    always_comb begin
        head           = r_mem[r_rd_ptr];
        o_valid        = r_count != '0;
        o_pixel_value  = head.pixel_value;
        o_channel_id   = head.channel_id;
        o_image_row    = head.image_row + {11'd0, r_second};
        o_image_column = head.image_column;
        o_last         = ~head.pair_of_rows | r_second;
        fire           = o_valid & i_ready;
        // drop the entry once its last result is taken
        pop            = fire & o_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
            if (fire) begin
                r_second <= ~o_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_count = r_count;

endmodule

// ===== rtl/ten_bit_unpack_channel_demux.sv =====
// Ten-bit packed pixel unpacker with channel demultiplexing. One raw byte is
// taken per cycle on the slave stream while tready is high; tuser high marks
// the first byte of a frame, where the configured number of leading bits is
// dropped. The rest is gathered MSB first into 10-bit words, and words inside
// the three index windows come out as pixels (sample shifted left by six) on
// the master stream: first window channel one even row, second window channel
// one odd row, third window channel two on both rows as two results, tlast on
// the last result of each word. A result is registered in the word register
// and then held in the result queue. Bytes flow at one per cycle as long as
// results are taken; a third-window word gives two results and takes ten bits,
// so a run of those stalls the input once the four-entry result queue fills.
// Configuration is written through the plain write port; the user must keep the
// stream idle while writing it, and the block itself does not enforce this.
module ten_bit_unpack_channel_demux
    import tbu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [23:0]            i_s_axis_tdata,  // byte_in[7:0], line_pair[18:8]
    input  logic                   i_s_axis_tuser,  // frame_start
    // master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [47:0]            o_m_axis_tdata,  // pixel_value[15:0],
                                                    // image_row[27:16],
                                                    // image_column[40:28]
    output logic                   o_m_axis_tuser,  // channel_id
    output logic                   o_m_axis_tlast   // last_of_run
);

    t_cfg              r_cfg;
    logic              accept;
    logic              word_valid;
    t_word             word;
    logic              push;
    t_pix_entry        entry;
    logic [QCNT_W-1:0] q_count;
    logic [15:0]       pixel_value;
    logic [11:0]       image_row;
    logic [12:0]       image_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_skip_bits      <= RST_LEAD_SKIP;
            r_cfg.frame_word_count    <= RST_FRAME_WORDS;
            r_cfg.line_width          <= RST_LINE_WIDTH;
            r_cfg.first_window_start  <= RST_FIRST_START;
            r_cfg.second_window_start <= RST_SECOND_START;
            r_cfg.third_window_start  <= RST_THIRD_START;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LEAD_SKIP:    r_cfg.lead_skip_bits      <= i_cfg_wdata[2:0];
                CFG_FRAME_WORDS:  r_cfg.frame_word_count    <= i_cfg_wdata[13:0];
                CFG_LINE_WIDTH:   r_cfg.line_width          <= i_cfg_wdata[12:0];
                CFG_FIRST_START:  r_cfg.first_window_start  <= i_cfg_wdata[13:0];
                CFG_SECOND_START: r_cfg.second_window_start <= i_cfg_wdata[13:0];
                CFG_THIRD_START:  r_cfg.third_window_start  <= i_cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    // leave room in the queue for the word in flight and this request
    assign o_s_axis_tready = (int'(q_count) + int'(word_valid)) < QUEUE_DEPTH;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    tbu_unpack u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_byte        (i_s_axis_tdata[7:0]),
        .i_frame_start (i_s_axis_tuser),
        .i_line_pair   (i_s_axis_tdata[18:8]),
        .o_word_valid  (word_valid),
        .o_word        (word)
    );

    tbu_window u_window (
        .i_cfg        (r_cfg),
        .i_word_valid (word_valid),
        .i_word       (word),
        .o_push       (push),
        .o_entry      (entry)
    );

    tbu_out_queue u_out_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_entry        (entry),
        .o_count        (q_count),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_pixel_value  (pixel_value),
        .o_channel_id   (o_m_axis_tuser),
        .o_image_row    (image_row),
        .o_image_column (image_column),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, image_column, image_row, pixel_value};

endmodule
